@@ sv/mkpq_pkg.sv @@
// Package for the multi-key priority queue: field widths, command and status
// codes, the entry and result types and the ordering function.
// No dependencies; every other file of the block imports it.
package mkpq_pkg;

  localparam int ID_W      = 31;
  localparam int CLS_W     = 2;
  localparam int DUE_W     = 44;
  localparam int CMD_W     = 2;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LIST = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Class "high", class "medium" and the class that collects all others.
  localparam logic [CLS_W-1:0] CLS_HIGH   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MEDIUM = 2'd1;
  localparam logic [CLS_W-1:0] CLS_OTHER  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CLS_W-1:0] cls;
    logic [DUE_W-1:0] due;
    logic             done;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_ROT
  } cell_op_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t op;
    entry_t   new_e;
    entry_t   head_e;
  } cell_ctl_t;

  typedef struct packed {
    logic                 has_entry;
    entry_t               e;
    logic [ST_W-1:0]      status;
    logic                 is_empty;
    logic [CNT_OUT_W-1:0] count;
    logic                 last;
  } res_t;

  // True when a is strictly ordered before b: class, then due time (a due
  // time beats none, earlier beats later), then the smaller id.
  function automatic logic goes_before(entry_t a, entry_t b);
    logic r;
    if (a.cls != b.cls) begin
      r = (a.cls < b.cls);
    end else if ((a.due != '0) && (b.due != '0) && (a.due != b.due)) begin
      r = (a.due < b.due);
    end else if ((a.due != '0) && (b.due == '0)) begin
      r = 1'b1;
    end else if ((a.due == '0) && (b.due != '0)) begin
      r = 1'b0;
    end else begin
      r = (a.id < b.id);
    end
    return r;
  endfunction

endpackage

@@ sv/mkpq_in_if.sv @@
// Command channel of the priority queue: valid/ready plus the command fields.
// Depends on mkpq_pkg for the field widths.
interface mkpq_in_if import mkpq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [ID_W-1:0]  task_id;
  logic [CLS_W-1:0] prio_class;
  logic [DUE_W-1:0] due_ms;
  logic             done_flag;

  modport source (output valid, cmd, task_id, prio_class, due_ms, done_flag,
                  input ready);
  modport sink (input valid, cmd, task_id, prio_class, due_ms, done_flag,
                output ready);
endinterface

@@ sv/mkpq_out_if.sv @@
// Result channel of the priority queue: valid/ready plus the result fields.
// Depends on mkpq_pkg for the field widths.
interface mkpq_out_if import mkpq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 has_entry;
  logic [ID_W-1:0]      out_id;
  logic [CLS_W-1:0]     out_class;
  logic [DUE_W-1:0]     out_due;
  logic                 out_done;
  logic [ST_W-1:0]      status;
  logic                 is_empty;
  logic [CNT_OUT_W-1:0] entry_count;
  logic                 last;

  modport source (output valid, has_entry, out_id, out_class, out_due, out_done,
                  status, is_empty, entry_count, last, input ready);
  modport sink (input valid, has_entry, out_id, out_class, out_due, out_done,
                status, is_empty, entry_count, last, output ready);
endinterface

@@ sv/multi_key_priority_queue_unit.sv @@
// Multi-key priority queue: a sorted chain of QUEUE_DEPTH cells, head in cell 0.
// Push, peek and pop give one result beat, registered at the accepting edge and
// shown on the next cycle; a new command is taken every cycle while the result
// side keeps up. A list of n entries streams n beats by rotating the chain, one
// per cycle while the result side keeps up; no command is taken until the last.
// Reset (rst_n, synchronous, active low) empties the queue and the result stage.
module multi_key_priority_queue_unit import mkpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mkpq_in_if.sink    in_ch,
  mkpq_out_if.source out_ch
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Chain wiring.
  entry_t                 cell_e [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_v;
  logic [QUEUE_DEPTH-1:0] cell_ins;
  cell_ctl_t              ctl;

  // Control and result stage.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] list_left_r, list_left_nxt;
  logic             list_busy_r, list_busy_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;

  logic             out_free;
  logic             acc;
  logic             full;
  logic             empty;
  entry_t           push_e;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  // The result stage can take a new beat when it is empty or being drained in
  // this cycle; a beat that waits on the result side holds off the next command.
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !list_busy_r && out_free;
  assign acc          = in_ch.valid && in_ch.ready;
  assign full         = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty        = (count_r == '0);

  // Class three is folded into the "other" class on entry.
  always_comb begin
    push_e.id   = in_ch.task_id;
    push_e.cls  = (in_ch.prio_class > CLS_OTHER) ? CLS_OTHER : in_ch.prio_class;
    push_e.due  = in_ch.due_ms;
    push_e.done = in_ch.done_flag;
  end

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      entry_t left_e, right_e;
      logic   left_v, left_i, right_v;
      if (gi == 0) begin : g_head
        assign left_e = cell_e[0];
        assign left_v = 1'b0;
        assign left_i = 1'b0;
      end else begin : g_mid_l
        assign left_e = cell_e[gi-1];
        assign left_v = cell_v[gi-1];
        assign left_i = cell_ins[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign right_e = cell_e[0];
        assign right_v = 1'b0;
      end else begin : g_mid_r
        assign right_e = cell_e[gi+1];
        assign right_v = cell_v[gi+1];
      end
      mkpq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .left_e      (left_e),
        .left_valid  (left_v),
        .left_ins    (left_i),
        .right_e     (right_e),
        .right_valid (right_v),
        .entry_q     (cell_e[gi]),
        .valid_q     (cell_v[gi]),
        .ins         (cell_ins[gi])
      );
    end
  endgenerate

  // Command decode. Every accepted command produces its first (often only)
  // beat right away; a list with more entries keeps going in list mode,
  // emitting the head and rotating the chain once per beat.
  always_comb begin
    ctl.op        = OP_HOLD;
    ctl.new_e     = push_e;
    ctl.head_e    = cell_e[0];
    count_nxt     = count_r;
    list_left_nxt = list_left_r;
    list_busy_nxt = list_busy_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;

    res_nxt.has_entry = 1'b0;
    res_nxt.e         = '0;
    res_nxt.status    = ST_OK;
    res_nxt.last      = 1'b1;

    if (acc) begin
      out_valid_nxt = 1'b1;
      case (in_ch.cmd)
        CMD_PUSH: begin
          if (full) begin
            res_nxt.status = ST_FULL;
          end else begin
            ctl.op    = OP_PUSH;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_PEEK, CMD_POP: begin
          if (empty) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            res_nxt.has_entry = 1'b1;
            res_nxt.e         = cell_e[0];
            if (in_ch.cmd == CMD_POP) begin
              ctl.op    = OP_POP;
              count_nxt = count_r - 1'b1;
            end
          end
        end
        default: begin
          // List: an empty queue gives one beat with no entry.
          if (!empty) begin
            ctl.op            = OP_ROT;
            res_nxt.has_entry = 1'b1;
            res_nxt.e         = cell_e[0];
            res_nxt.last      = (count_r == CNT_W'(1));
            list_left_nxt     = count_r - 1'b1;
            list_busy_nxt     = (count_r != CNT_W'(1));
          end
        end
      endcase
    end else if (list_busy_r && out_free) begin
      out_valid_nxt     = 1'b1;
      ctl.op            = OP_ROT;
      res_nxt.has_entry = 1'b1;
      res_nxt.e         = cell_e[0];
      res_nxt.last      = (list_left_r == CNT_W'(1));
      list_left_nxt     = list_left_r - 1'b1;
      list_busy_nxt     = (list_left_r != CNT_W'(1));
    end else begin
      res_nxt = res_r;
    end

    // Count fields report the state after the command.
    cnt_ext          = (CNT_W+CNT_OUT_W)'(count_nxt);
    if (acc || (list_busy_r && out_free)) begin
      res_nxt.is_empty = (count_nxt == '0);
      res_nxt.count    = cnt_ext[CNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      list_busy_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      list_busy_r <= list_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    list_left_r <= list_left_nxt;
    res_r       <= res_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.has_entry   = res_r.has_entry;
  assign out_ch.out_id      = res_r.e.id;
  assign out_ch.out_class   = res_r.e.cls;
  assign out_ch.out_due     = res_r.e.due;
  assign out_ch.out_done    = res_r.e.done;
  assign out_ch.status      = res_r.status;
  assign out_ch.is_empty    = res_r.is_empty;
  assign out_ch.entry_count = res_r.count;
  assign out_ch.last        = res_r.last;

  // Occupied cells always form one run starting at the head.
  logic [QUEUE_DEPTH-1:0] cell_v_inc;
  assign cell_v_inc = cell_v + 1'b1;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_v) == int'(count_r))
    else $error("held count differs from the number of occupied cells");

  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_v & cell_v_inc) == '0)
    else $error("occupied cells do not form a run from the head");

  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_v[1] && !list_busy_r) |-> !goes_before(cell_e[1], cell_e[0]))
    else $error("second cell is ordered before the head");

  a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (list_busy_r && out_free && (list_left_r == CNT_W'(1))) |=> !list_busy_r)
    else $error("list mode outlived its final beat");

endmodule

@@ sv/mkpq_cell.sv @@
// One cell of the sorted chain: holds one entry and its valid bit, compares a
// pushed entry against its own and shifts with its neighbors. Uses mkpq_pkg.
module mkpq_cell import mkpq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  entry_t    left_e,
  input  logic      left_valid,
  input  logic      left_ins,
  input  entry_t    right_e,
  input  logic      right_valid,
  output entry_t    entry_q,
  output logic      valid_q,
  output logic      ins
);

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;
  logic   take_new, take_left;

  // The pushed entry belongs here or further toward the head.
  assign ins       = !valid_r || goes_before(ctl.new_e, entry_r);
  assign take_left = left_ins && left_valid;
  assign take_new  = ins && !left_ins;

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    case (ctl.op)
      OP_PUSH: begin
        if (take_left) begin
          entry_nxt = left_e;
        end else if (take_new) begin
          entry_nxt = ctl.new_e;
        end
        valid_nxt = valid_r || take_left || take_new;
      end
      OP_POP: begin
        entry_nxt = right_e;
        valid_nxt = right_valid;
      end
      OP_ROT: begin
        // The tail of the occupied run takes the head, closing the ring.
        entry_nxt = right_valid ? right_e : ctl.head_e;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;
  assign valid_q = valid_r;

endmodule
